// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the lane marking classifier RTL.
// Both macros sample on the rising edge of clock and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LMWC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LMWC_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define LMWC_ASSERT(lbl, prop, msg)
`define LMWC_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/core/lmwc_pkg.sv
`default_nettype none

package lmwc_pkg;

   localparam int MAX_BANDS = 3;

   localparam logic [16:0] CNT_MAX  = 17'h1FFFF;
   localparam logic [9:0]  QUAL_MAX = 10'h3FF;

   // csr register indexes
   localparam logic [2:0] CSR_CENTER_LEFT   = 3'd0;
   localparam logic [2:0] CSR_CENTER_MIDDLE = 3'd1;
   localparam logic [2:0] CSR_CENTER_RIGHT  = 3'd2;
   localparam logic [2:0] CSR_HALF_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_WINDOW_ROWS   = 3'd4;
   localparam logic [2:0] CSR_WHITE_LEVEL   = 3'd5;
   localparam logic [2:0] CSR_WINDOWS_FRAME = 3'd6;

   typedef enum logic [1:0] {
      CLASS_NONE   = 2'd0,
      CLASS_DASHED = 2'd1,
      CLASS_SOLID  = 2'd2
   } lane_class_type;

   typedef struct packed {
      logic [MAX_BANDS-1:0][10:0] center;
      logic [7:0]                 half_width;
      logic [7:0]                 window_rows;
      logic [7:0]                 white_level;
      logic [9:0]                 windows_per_frame;
   } cfg_type;

   // one classified pixel, front to back
   typedef struct packed {
      logic [MAX_BANDS-1:0] hit;
      logic                 close;
      logic                 frame_end;
   } tok_type;

   // one step of restoring remainder; r < div on entry and on exit
   function automatic logic [7:0] rem_step(logic [7:0] r, logic bit_in, logic [7:0] div);
      logic [8:0] t;
      t = {r, bit_in};
      if (t >= {1'b0, div}) begin
         return 8'(t - {1'b0, div});
      end
      return t[7:0];
   endfunction

   // q qualifying windows against t nominal: solid at 85 %, dashed at 50 %
   function automatic lane_class_type classify(logic [9:0] q, logic [9:0] t,
                                                logic [14:0] t17);
      logic [14:0] q20;
      q20 = 15'({q, 4'b0}) + 15'({q, 2'b0});
      if (q20 >= t17) begin
         return CLASS_SOLID;
      end
      if ({q, 1'b0} >= {1'b0, t}) begin
         return CLASS_DASHED;
      end
      return CLASS_NONE;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/lmwc_front.sv
`default_nettype none

module lmwc_front #(
   parameter int FRAME_ROWS = 720,
   parameter int FRAME_COLS = 1280,
   parameter int NUM_BANDS  = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  logic [7:0]        pixel,
   input  logic [9:0]        row,
   input  logic [10:0]       col,
   input  logic              frame_end,
   input  lmwc_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              push,
   output lmwc_pkg::tok_type tok
);

   localparam logic [9:0]  ROW_LIMIT = 10'(FRAME_ROWS);
   localparam logic [10:0] COL_LIMIT = 11'(FRAME_COLS);
   localparam logic [9:0]  LAST_ROW  = 10'(FRAME_ROWS - 1);
   localparam logic [10:0] LAST_COL  = 11'(FRAME_COLS - 1);

   logic        adv;
   logic        s1_valid_ff;
   logic [7:0]  s1_pixel_ff;
   logic [9:0]  s1_row_ff;
   logic [10:0] s1_col_ff;
   logic        s1_fe_ff;

   logic                           s2_valid_ff;
   logic [lmwc_pkg::MAX_BANDS-1:0] s2_hit_ff, s2_hit_in;
   logic                           s2_last_ff, s2_last_in;
   logic                           s2_fe_ff;
   logic [7:0]                     s2_rem_ff, s2_rem_in;
   logic [4:0]                     s2_dlo_ff, s2_dlo_in;

   logic [7:0] div;

   assign adv      = !(s2_valid_ff && q_full);
   assign in_stall = !adv;
   assign push     = s2_valid_ff && !q_full;
   assign div      = (cfg.window_rows == 8'd0) ? 8'd1 : cfg.window_rows;

   // stage 1: window membership per band and top half of the row remainder
   always_comb begin
      logic              in_frame;
      logic              white;
      logic [9:0]        dividend;
      logic [7:0]        r;
      logic signed [12:0] lo;
      logic signed [12:0] col_s;
      logic [11:0]       hi;
      in_frame = (s1_row_ff < ROW_LIMIT) && (s1_col_ff < COL_LIMIT);
      white    = s1_pixel_ff >= cfg.white_level;
      dividend = LAST_ROW - s1_row_ff;
      col_s    = $signed({2'b0, s1_col_ff});
      r        = 8'd0;
      for (int i = 0; i < 5; i++) begin
         r = lmwc_pkg::rem_step(r, dividend[9-i], div);
      end
      for (int b = 0; b < lmwc_pkg::MAX_BANDS; b++) begin
         lo = $signed({2'b0, cfg.center[b]}) - $signed({5'b0, cfg.half_width});
         hi = {1'b0, cfg.center[b]} + {4'b0, cfg.half_width};
         s2_hit_in[b] = (b < NUM_BANDS) && in_frame && white &&
                        (col_s >= lo) && ({1'b0, s1_col_ff} < hi);
      end
      s2_last_in = in_frame && (s1_col_ff == LAST_COL);
      s2_rem_in  = r;
      s2_dlo_in  = dividend[4:0];
   end

   // stage 2: finish remainder, a zero on the last column closes the window
   always_comb begin
      logic [7:0] r;
      r = s2_rem_ff;
      for (int i = 4; i >= 0; i--) begin
         r = lmwc_pkg::rem_step(r, s2_dlo_ff[i], div);
      end
      tok.hit       = s2_hit_ff;
      tok.close     = s2_last_ff && (r == 8'd0);
      tok.frame_end = s2_fe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pixel_ff <= pixel;
         s1_row_ff   <= row;
         s1_col_ff   <= col;
         s1_fe_ff    <= frame_end;
         s2_hit_ff   <= s2_hit_in;
         s2_last_ff  <= s2_last_in;
         s2_fe_ff    <= s1_fe_ff;
         s2_rem_ff   <= s2_rem_in;
         s2_dlo_ff   <= s2_dlo_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lmwc_queue.sv
`default_nettype none
`include "assert_macros.svh"

module lmwc_queue #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

   `LMWC_NEVER(a_no_push_full, push && full, "queue written while full")
   `LMWC_NEVER(a_no_pop_empty, pop && empty, "queue read while empty")
   `LMWC_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// File: rtl/core/lmwc_back.sv
`default_nettype none
`include "assert_macros.svh"

module lmwc_back #(
   parameter int NUM_BANDS = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lmwc_pkg::cfg_type                     cfg,
   input  logic                                  q_empty,
   input  lmwc_pkg::tok_type                     tok,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lmwc_pkg::MAX_BANDS-1:0][1:0]   rsp_type
);

   localparam int NB = lmwc_pkg::MAX_BANDS;

   logic [NB-1:0][16:0] cnt_ff, cnt_in;
   logic [NB-1:0][9:0]  qual_ff, qual_in;
   logic [NB-1:0]       qinc_in;
   logic [17:0]         area_ff;
   logic [14:0]         t17_ff;

   logic          b2_valid_ff;
   logic [NB-1:0] b2_qinc_ff;
   logic          b2_fe_ff;

   logic                rsp_valid_ff;
   logic [NB-1:0][1:0]  rsp_type_ff, rsp_type_in;

   logic back_adv;
   logic b2_fire;
   logic eval;

   assign back_adv  = !(b2_valid_ff && b2_fe_ff && rsp_valid_ff && rsp_stall);
   assign pop       = !q_empty && back_adv;
   assign b2_fire   = b2_valid_ff && back_adv;
   assign eval      = tok.close || tok.frame_end;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_type  = rsp_type_ff;

   // window counts; a closing or frame-end transfer tests the updated count against the area
   always_comb begin
      logic [16:0] c;
      logic [20:0] c10;
      for (int b = 0; b < NB; b++) begin
         c = cnt_ff[b];
         if (tok.hit[b] && (cnt_ff[b] != lmwc_pkg::CNT_MAX)) begin
            c = cnt_ff[b] + 1'b1;
         end
         c10        = 21'({c, 3'b0}) + 21'({c, 1'b0});
         qinc_in[b] = eval && (c10 > 21'(area_ff));
         cnt_in[b]  = eval ? 17'd0 : c;
      end
   end

   // qualifying window tally and classing at frame end
   always_comb begin
      logic [9:0] q;
      for (int b = 0; b < NB; b++) begin
         q = qual_ff[b];
         if (b2_qinc_ff[b] && (qual_ff[b] != lmwc_pkg::QUAL_MAX)) begin
            q = qual_ff[b] + 1'b1;
         end
         qual_in[b] = b2_fe_ff ? 10'd0 : q;
         rsp_type_in[b] = (b < NUM_BANDS) ?
                          2'(lmwc_pkg::classify(q, cfg.windows_per_frame, t17_ff)) :
                          2'(lmwc_pkg::CLASS_NONE);
      end
   end

   always_ff @(posedge clock) begin
      logic [15:0] prod;
      prod    = ((cfg.window_rows == 8'd0) ? 8'd1 : cfg.window_rows) * cfg.half_width;
      area_ff <= 18'({prod, 1'b0}) + 18'(prod);
      t17_ff  <= 15'({cfg.windows_per_frame, 4'b0}) + 15'(cfg.windows_per_frame);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         qual_ff      <= '0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cnt_ff <= cnt_in;
         end
         if (back_adv) begin
            b2_valid_ff <= pop;
         end
         if (b2_fire) begin
            qual_ff <= qual_in;
         end
         if (b2_fire && b2_fe_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         b2_qinc_ff <= qinc_in;
         b2_fe_ff   <= tok.frame_end;
      end
      if (b2_fire && b2_fe_ff) begin
         rsp_type_ff <= rsp_type_in;
      end
   end

   `LMWC_ASSERT(a_out_free, (b2_fire && b2_fe_ff) |-> (!rsp_valid_ff || !rsp_stall), "result overwritten")
   `LMWC_ASSERT(a_cnt_clear, (pop && eval) |=> (cnt_ff == '0), "window count not cleared on close")
   `LMWC_ASSERT(a_frame_done, (b2_fire && b2_fe_ff) |=> (rsp_valid_ff && qual_ff == '0), "frame end left state")

endmodule

`default_nettype wire

// File: rtl/core/lane_marking_window_classifier_unit.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+----------------------------------------
// req       | in        | req_valid/req_stall  | req_pixel, req_row, req_col, req_frame_end
// rsp       | out       | rsp_valid/rsp_stall  | rsp_type_left, rsp_type_middle, rsp_type_right
// csr       | in        | csr_write            | csr_index, csr_wdata
//
// One pixel transfer per cycle while req_stall is low; a pixel reaches the band
// counters through the two front stages and the queue.
// The row remainder for window closing is split over the two front stages.
// A result is offered once the frame end pixel has left the queue and the tally stage.
// Reset is synchronous; all counts clear and configuration takes its defaults.
// req_stall rises only while the queue is full, which happens when a result
// waits on rsp_stall and a further frame end reaches the back end.
`default_nettype none

module lane_marking_window_classifier_unit #(
   parameter int FRAME_ROWS  = 720,
   parameter int FRAME_COLS  = 1280,
   parameter int NUM_BANDS   = 3,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // pixel stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic [9:0]  req_row,
   input  logic [10:0] req_col,
   input  logic        req_frame_end,
   // lane type result, one per frame
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_type_left,
   output logic [1:0]  rsp_type_middle,
   output logic [1:0]  rsp_type_right,
   // register writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int TOK_W = $bits(lmwc_pkg::tok_type);

   // configuration registers
   logic [10:0] center_left_ff;
   logic [10:0] center_middle_ff;
   logic [10:0] center_right_ff;
   logic [7:0]  half_width_ff;
   logic [7:0]  window_rows_ff;
   logic [7:0]  white_level_ff;
   logic [9:0]  windows_frame_ff;

   lmwc_pkg::cfg_type cfg;

   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   lmwc_pkg::tok_type front_tok;
   lmwc_pkg::tok_type head_tok;

   logic [lmwc_pkg::MAX_BANDS-1:0][1:0] rsp_type;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_left_ff   <= 11'd320;
         center_middle_ff <= 11'd640;
         center_right_ff  <= 11'd960;
         half_width_ff    <= 8'd90;
         window_rows_ff   <= 8'd80;
         white_level_ff   <= 8'd200;
         windows_frame_ff <= 10'd9;
      end else if (csr_write) begin
         unique case (csr_index)
            lmwc_pkg::CSR_CENTER_LEFT:   center_left_ff   <= csr_wdata;
            lmwc_pkg::CSR_CENTER_MIDDLE: center_middle_ff <= csr_wdata;
            lmwc_pkg::CSR_CENTER_RIGHT:  center_right_ff  <= csr_wdata;
            lmwc_pkg::CSR_HALF_WIDTH:    half_width_ff    <= csr_wdata[7:0];
            lmwc_pkg::CSR_WINDOW_ROWS:   window_rows_ff   <= csr_wdata[7:0];
            lmwc_pkg::CSR_WHITE_LEVEL:   white_level_ff   <= csr_wdata[7:0];
            lmwc_pkg::CSR_WINDOWS_FRAME: windows_frame_ff <= csr_wdata[9:0];
            default: ; // index beyond the register list: write dropped
         endcase
      end
   end

   always_comb begin
      cfg.center[0]         = center_left_ff;
      cfg.center[1]         = center_middle_ff;
      cfg.center[2]         = center_right_ff;
      cfg.half_width        = half_width_ff;
      cfg.window_rows       = window_rows_ff;
      cfg.white_level       = white_level_ff;
      cfg.windows_per_frame = windows_frame_ff;
   end

   // front end: band hits, threshold and window-bottom detection per pixel
   lmwc_front #(
      .FRAME_ROWS (FRAME_ROWS),
      .FRAME_COLS (FRAME_COLS),
      .NUM_BANDS  (NUM_BANDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .pixel     (req_pixel),
      .row       (req_row),
      .col       (req_col),
      .frame_end (req_frame_end),
      .cfg       (cfg),
      .q_full    (q_full),
      .push      (q_push),
      .tok       (front_tok)
   );

   // decouples pixel intake from result back-pressure
   lmwc_queue #(
      .WIDTH (TOK_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (front_tok),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (head_tok),
      .empty (q_empty)
   );

   // back end: window counters, qualifying tallies and frame-end classing
   lmwc_back #(
      .NUM_BANDS (NUM_BANDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .tok       (head_tok),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_type  (rsp_type)
   );

   assign rsp_type_left   = rsp_type[0];
   assign rsp_type_middle = rsp_type[1];
   assign rsp_type_right  = rsp_type[2];

endmodule

`default_nettype wire

// File: sim/lmwc_lane_type_checker.sv
// Watches the pixel, result and register ports, tracks the band counts and
// checks each lane type result against the oldest owed one.
module lmwc_lane_type_checker #(
   parameter int FRAME_ROWS = 720,
   parameter int FRAME_COLS = 1280,
   parameter int NUM_BANDS  = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic [9:0]  req_row,
   input  logic [10:0] req_col,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_type_left,
   input  logic [1:0]  rsp_type_middle,
   input  logic [1:0]  rsp_type_right,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata,
   output int          mismatch_total,
   output int          results_owed
);

   typedef struct packed {
      lmwc_pkg::lane_class_type left;
      lmwc_pkg::lane_class_type middle;
      lmwc_pkg::lane_class_type right;
   } lane_set_type;

   logic [10:0] centre [3];
   logic [7:0]  half_width;
   logic [7:0]  window_rows;
   logic [7:0]  white_level;
   logic [9:0]  windows_per_frame;

   logic [16:0] white_count [3];
   logic [9:0]  qual_count [3];
   logic [7:0]  rows_seen;

   lane_set_type owed_types [$];
   int           mismatches = 0;

   function automatic int rows_eff();
      return (window_rows == 8'd0) ? 1 : int'(window_rows);
   endfunction

   // 85 % and 50 % by cross-multiplication
   function automatic lmwc_pkg::lane_class_type band_class(int b);
      int q;
      int t;
      if (b >= NUM_BANDS) return lmwc_pkg::CLASS_NONE;
      q = int'(qual_count[b]);
      t = int'(windows_per_frame);
      if (q * 20 >= t * 17) return lmwc_pkg::CLASS_SOLID;
      if (q * 2 >= t) return lmwc_pkg::CLASS_DASHED;
      return lmwc_pkg::CLASS_NONE;
   endfunction

   // a window qualifies above 0.15 of its area, 2 * half_width columns by its rows
   function automatic void close_windows();
      int area;
      area = 3 * rows_eff() * int'(half_width);
      for (int b = 0; b < NUM_BANDS; b++) begin
         if (int'(white_count[b]) * 10 > area && qual_count[b] != lmwc_pkg::QUAL_MAX)
            qual_count[b] = qual_count[b] + 10'd1;
         white_count[b] = '0;
      end
      rows_seen = '0;
   endfunction

   always @(posedge clock) begin : track
      lane_set_type want;
      bit           closed;
      int           lo;
      int           hi;
      if (reset) begin
         centre[0]         = 11'd320;
         centre[1]         = 11'd640;
         centre[2]         = 11'd960;
         half_width        = 8'd90;
         window_rows       = 8'd80;
         white_level       = 8'd200;
         windows_per_frame = 10'd9;
         for (int b = 0; b < 3; b++) begin
            white_count[b] = '0;
            qual_count[b]  = '0;
         end
         rows_seen = '0;
         owed_types.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               lmwc_pkg::CSR_CENTER_LEFT:   centre[0] = csr_wdata;
               lmwc_pkg::CSR_CENTER_MIDDLE: centre[1] = csr_wdata;
               lmwc_pkg::CSR_CENTER_RIGHT:  centre[2] = csr_wdata;
               lmwc_pkg::CSR_HALF_WIDTH:    half_width = csr_wdata[7:0];
               lmwc_pkg::CSR_WINDOW_ROWS:   window_rows = csr_wdata[7:0];
               lmwc_pkg::CSR_WHITE_LEVEL:   white_level = csr_wdata[7:0];
               lmwc_pkg::CSR_WINDOWS_FRAME: windows_per_frame = csr_wdata[9:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (owed_types.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected lane type result %0d %0d %0d",
                           rsp_type_left, rsp_type_middle, rsp_type_right);
               mismatches++;
            end else begin
               want = owed_types.pop_front();
               if (rsp_type_left !== want.left || rsp_type_middle !== want.middle ||
                   rsp_type_right !== want.right) begin
                  if (mismatches < 10)
                     $display("lane type mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              want.left, want.middle, want.right,
                              rsp_type_left, rsp_type_middle, rsp_type_right);
                  mismatches++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            closed = 1'b0;
            if (int'(req_row) < FRAME_ROWS && int'(req_col) < FRAME_COLS) begin
               if (req_pixel >= white_level) begin
                  for (int b = 0; b < NUM_BANDS; b++) begin
                     lo = int'(centre[b]) - int'(half_width);
                     hi = int'(centre[b]) + int'(half_width);
                     if (int'(req_col) >= lo && int'(req_col) < hi &&
                         white_count[b] != lmwc_pkg::CNT_MAX)
                        white_count[b] = white_count[b] + 17'd1;
                  end
               end
               // last column of a row; windows align to the frame bottom
               if (int'(req_col) == FRAME_COLS - 1) begin
                  if (rows_seen != 8'hFF) rows_seen = rows_seen + 8'd1;
                  if ((FRAME_ROWS - 1 - int'(req_row)) % rows_eff() == 0) begin
                     close_windows();
                     closed = 1'b1;
                  end
               end
            end
            if (req_frame_end) begin
               if (!closed) close_windows();
               want.left   = band_class(0);
               want.middle = band_class(1);
               want.right  = band_class(2);
               owed_types.insert(owed_types.size(), want);
               for (int b = 0; b < 3; b++) begin
                  white_count[b] = '0;
                  qual_count[b]  = '0;
               end
               rows_seen = '0;
            end
         end
      end
      mismatch_total <= mismatches;
      results_owed   <= owed_types.size();
   end

endmodule

// File: sim/tb_lane_marking_window_classifier_unit.sv
// Stimulus and verdict only; prediction and comparison live in the checker.
module tb_lane_marking_window_classifier_unit;

   localparam int FRAME_ROWS   = 720;
   localparam int FRAME_COLS   = 1280;
   localparam int NUM_BANDS    = 3;
   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1750;
   // front stages, queue, count stage and result stages, with margin
   localparam int DRAIN_CYCLES = 16;
   localparam int LIMIT_CYCLES = 400000;
   // unmapped register index, writes to it must change nothing
   localparam logic [2:0] CSR_SPARE = 3'd7;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel       = '0;
   logic [9:0]  req_row         = '0;
   logic [10:0] req_col         = '0;
   logic        req_frame_end   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_type_left;
   logic [1:0]  rsp_type_middle;
   logic [1:0]  rsp_type_right;
   logic        csr_write       = 1'b0;
   logic [2:0]  csr_index       = '0;
   logic [10:0] csr_wdata       = '0;

   int mismatch_total;
   int results_owed;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;

   // stimulus-side copy of the set-up, used only to aim pixels at the bands
   int cfg_centre [3] = '{320, 640, 960};
   int cfg_half       = 90;
   int cfg_rows       = 80;
   int cfg_level      = 200;

   lane_marking_window_classifier_unit #(
      .FRAME_ROWS (FRAME_ROWS),
      .FRAME_COLS (FRAME_COLS),
      .NUM_BANDS  (NUM_BANDS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_type_left   (rsp_type_left),
      .rsp_type_middle (rsp_type_middle),
      .rsp_type_right  (rsp_type_right),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   lmwc_lane_type_checker #(
      .FRAME_ROWS (FRAME_ROWS),
      .FRAME_COLS (FRAME_COLS),
      .NUM_BANDS  (NUM_BANDS)
   ) lane_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_type_left   (rsp_type_left),
      .rsp_type_middle (rsp_type_middle),
      .rsp_type_right  (rsp_type_right),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_total  (mismatch_total),
      .results_owed    (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= (int'($urandom_range(0, 99)) < recv_stall_pct);
   end

   // one pixel transfer; optional idle cycles first, then hold until taken
   task automatic push_pixel(int pixel, int row, int col, bit frame_end);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel     <= 8'(pixel);
      req_row       <= 10'(row);
      req_col       <= 11'(col);
      req_frame_end <= frame_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // one register write; caller lowers csr_write after the batch
   task automatic set_reg(logic [2:0] idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 11'(value);
      case (idx)
         lmwc_pkg::CSR_CENTER_LEFT:   cfg_centre[0] = value;
         lmwc_pkg::CSR_CENTER_MIDDLE: cfg_centre[1] = value;
         lmwc_pkg::CSR_CENTER_RIGHT:  cfg_centre[2] = value;
         lmwc_pkg::CSR_HALF_WIDTH:    cfg_half = value;
         lmwc_pkg::CSR_WINDOW_ROWS:   cfg_rows = value;
         lmwc_pkg::CSR_WHITE_LEVEL:   cfg_level = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // stop sending, let every owed result arrive, then let the pipe empty.
   // The first edge lets the checker's count catch up with the last transfer.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // fresh random set-up: mostly narrow bands and short windows so that
   // windows can qualify with few pixels, now and then the extremes
   task automatic program_setup();
      for (int b = 0; b < 3; b++) begin
         case ($urandom_range(0, 7))
            0:       set_reg(3'(lmwc_pkg::CSR_CENTER_LEFT + b), 0);
            1:       set_reg(3'(lmwc_pkg::CSR_CENTER_LEFT + b), 2047);
            default: set_reg(3'(lmwc_pkg::CSR_CENTER_LEFT + b),
                             $urandom_range(0, FRAME_COLS - 1));
         endcase
      end
      case ($urandom_range(0, 9))
         0:       set_reg(lmwc_pkg::CSR_HALF_WIDTH, 0);
         1:       set_reg(lmwc_pkg::CSR_HALF_WIDTH, 255);
         default: set_reg(lmwc_pkg::CSR_HALF_WIDTH, $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0:       set_reg(lmwc_pkg::CSR_WINDOW_ROWS, 0);
         1:       set_reg(lmwc_pkg::CSR_WINDOW_ROWS, 255);
         2:       set_reg(lmwc_pkg::CSR_WINDOW_ROWS, $urandom_range(6, 40));
         default: set_reg(lmwc_pkg::CSR_WINDOW_ROWS, $urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 7))
         0:       set_reg(lmwc_pkg::CSR_WHITE_LEVEL, 0);
         1:       set_reg(lmwc_pkg::CSR_WHITE_LEVEL, 255);
         default: set_reg(lmwc_pkg::CSR_WHITE_LEVEL, $urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
         0:       set_reg(lmwc_pkg::CSR_WINDOWS_FRAME, 0);
         1:       set_reg(lmwc_pkg::CSR_WINDOWS_FRAME, 1023);
         default: set_reg(lmwc_pkg::CSR_WINDOWS_FRAME, $urandom_range(1, 7));
      endcase
      csr_write <= 1'b0;
   endtask

   // One short frame: a few windows near the frame bottom, top to bottom,
   // each with some pixels in and just outside the bands, then the last
   // column of its bottom row to close it. Now and then a closing pixel is
   // dropped (windows merge) or a noise pixel with any field values slips in.
   task automatic send_frame();
      int  rows_eff;
      int  wins;
      int  k;
      int  bottom;
      int  top_row;
      int  col;
      int  band;
      int  pix;
      bit  ended;
      rows_eff = (cfg_rows == 0) ? 1 : cfg_rows;
      wins     = $urandom_range(1, 6);
      k        = $urandom_range(wins - 1, wins + 1);
      if (k > (FRAME_ROWS - 1) / rows_eff) k = (FRAME_ROWS - 1) / rows_eff;
      ended = 1'b0;
      for (; k >= 0 && !ended; k--) begin
         bottom  = FRAME_ROWS - 1 - k * rows_eff;
         top_row = (bottom - rows_eff + 1 < 0) ? 0 : bottom - rows_eff + 1;
         repeat ($urandom_range(0, 7)) begin
            if ($urandom_range(0, 11) == 0) begin
               push_pixel($urandom_range(0, 255), $urandom_range(0, 1023),
                          $urandom_range(0, 2047), $urandom_range(0, 29) == 0);
            end else begin
               band = $urandom_range(0, 2);
               // one column past each band edge included
               col  = cfg_centre[band] - cfg_half - 1 +
                      int'($urandom_range(0, 2 * cfg_half + 1));
               if (col < 0) col = 0;
               if (col > 2047) col = 2047;
               pix  = ($urandom_range(0, 3) != 0) ? int'($urandom_range(cfg_level, 255))
                                                  : int'($urandom_range(0, 255));
               push_pixel(pix, $urandom_range(top_row, bottom), col, 1'b0);
            end
         end
         if ($urandom_range(0, 7) != 0) begin
            // frame end may fall on the closing pixel of the bottom window
            ended = (k == 0) && ($urandom_range(0, 1) == 1);
            push_pixel($urandom_range(0, 255), bottom, FRAME_COLS - 1, ended);
         end
      end
      // early frame end: open window is evaluated as it stands
      if (!ended)
         push_pixel($urandom_range(0, 255), $urandom_range(0, 1023),
                    $urandom_range(0, 2047), 1'b1);
   endtask

   initial begin : stimulus
      int base;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset set-up: left band covers columns 230 to 409
      push_pixel(0, 0, 0, 1'b0);
      push_pixel(255, 1023, 2047, 1'b0);            // beyond the frame, ignored
      push_pixel(255, FRAME_ROWS - 1, 230, 1'b0);   // lower band edge
      push_pixel(255, FRAME_ROWS - 1, 409, 1'b0);   // upper band edge
      push_pixel(255, FRAME_ROWS - 1, 410, 1'b0);   // just past it
      push_pixel(200, FRAME_ROWS - 1, FRAME_COLS - 1, 1'b0);
      push_pixel(199, 1023, 0, 1'b1);               // early end off the frame
      push_pixel(255, 639, FRAME_COLS - 1, 1'b1);   // end on a closing pixel
      settle();

      // bands hanging off both frame edges, zero rows and zero window count
      set_reg(lmwc_pkg::CSR_CENTER_LEFT, 0);
      set_reg(lmwc_pkg::CSR_CENTER_MIDDLE, 2047);
      set_reg(lmwc_pkg::CSR_CENTER_RIGHT, FRAME_COLS - 1);
      set_reg(lmwc_pkg::CSR_HALF_WIDTH, 1);
      set_reg(lmwc_pkg::CSR_WINDOW_ROWS, 0);
      set_reg(lmwc_pkg::CSR_WHITE_LEVEL, 0);
      set_reg(lmwc_pkg::CSR_WINDOWS_FRAME, 0);
      set_reg(CSR_SPARE, 2047);
      csr_write <= 1'b0;
      push_pixel(0, FRAME_ROWS - 1, 0, 1'b0);
      push_pixel(0, FRAME_ROWS - 1, 2046, 1'b0);
      push_pixel(0, FRAME_ROWS - 2, FRAME_COLS - 1, 1'b0);
      push_pixel(0, FRAME_ROWS - 1, FRAME_COLS - 1, 1'b1);
      settle();

      // widest settings
      set_reg(lmwc_pkg::CSR_CENTER_MIDDLE, 640);
      set_reg(lmwc_pkg::CSR_HALF_WIDTH, 255);
      set_reg(lmwc_pkg::CSR_WINDOW_ROWS, 255);
      set_reg(lmwc_pkg::CSR_WHITE_LEVEL, 255);
      set_reg(lmwc_pkg::CSR_WINDOWS_FRAME, 1023);
      csr_write <= 1'b0;
      push_pixel(255, FRAME_ROWS - 1 - 255, FRAME_COLS - 1, 1'b0);
      push_pixel(254, 0, 600, 1'b1);

      // random frames under three idling regimes
      base = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         settle();
         if (phase == 0) begin
            send_idle_pct  = 13;
            recv_stall_pct = 52;
         end else if (phase == 1) begin
            send_idle_pct  = 52;
            recv_stall_pct = 13;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         while (items_sent < base + RANDOM_ITEMS * (phase + 1) / 3) begin
            settle();
            program_setup();
            repeat ($urandom_range(1, 3)) send_frame();
         end
      end

      settle();
      if (mismatch_total == 0) begin
         $display("lane_marking_window_classifier_unit regression: pass");
      end else begin
         $display("lane_marking_window_classifier_unit regression: fail");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("lane_marking_window_classifier_unit regression: fail");
      $finish;
   end

endmodule
